>>> sv/arenv_pkg.sv
package arenv_pkg;

  // Field and register widths.
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 24;
  localparam int TIME_BITS    = 16;
  localparam int FRAC_BITS    = TIME_BITS - 4;
  localparam int RATE_BITS    = 18;
  localparam int THR_BITS     = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = RATE_BITS;

  // Serial datapath widths: Q.62 operands carry one extra bit so 1.0 fits.
  localparam int QW        = 63;
  localparam int PW        = 2 * QW;
  localparam int DEN_BITS  = RATE_BITS + TIME_BITS;
  localparam int NUM_BITS  = 19;
  localparam int DVD_BITS  = 64;
  localparam int CNT_BITS  = 6;
  localparam int XQ_BITS   = 37;
  localparam int XSH       = 20;

  localparam logic [NUM_BITS-1:0]  NUM_SHORT   = NUM_BITS'(100000);
  localparam logic [NUM_BITS-1:0]  NUM_LONG    = NUM_BITS'(100 << FRAC_BITS);
  // A setting counts as short when raw * 1000 < 2^FRAC_BITS.
  localparam logic [TIME_BITS-1:0] SHORT_LIMIT =
    TIME_BITS'(((1 << FRAC_BITS) + 999) / 1000);
  localparam logic [QW-1:0]        Q_ONE       = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0]        COEF_RND    = QW'(1) << (61 - COEF_BITS);

  localparam logic [CNT_BITS-1:0] MUL_STEPS  = CNT_BITS'(QW);
  localparam logic [CNT_BITS-1:0] XDIV_STEPS = CNT_BITS'(NUM_BITS + 32);
  localparam logic [CNT_BITS-1:0] SDIV_STEPS = CNT_BITS'(QW);
  localparam logic [2:0]          HORNER_TERMS = 3'd6;
  localparam logic [3:0]          LAST_SQUARE  = 4'd9;

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);
  localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(8);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_THR  = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]          attack_time;
    logic [TIME_BITS-1:0]          decay_time;
  } arenv_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] level;
    logic                   settled;
  } arenv_out_t;

  // Round a full product to Q.62, half up.
  function automatic logic [QW-1:0] rnd_q62(input logic [PW-1:0] p);
    logic [QW:0] s;
    s = p[PW-1:62] + {{QW{1'b0}}, p[61]};
    return s[QW-1:0];
  endfunction

endpackage

>>> sv/arenv_mul.sv
module arenv_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [arenv_pkg::QW-1:0] a,
  input  logic [arenv_pkg::QW-1:0] b,
  output logic [arenv_pkg::PW-1:0] prod,
  output logic                    done
);
  import arenv_pkg::*;

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [QW-1:0]       a_r;
  logic [QW-1:0]       b_r;
  logic [QW-1:0]       ph;
  logic [QW-1:0]       pl;
  logic [QW:0]         sum;

  // One multiplier bit per cycle, LSB first, shift-add.
  assign sum  = {1'b0, ph} + (b_r[0] ? {1'b0, a_r} : {(QW+1){1'b0}});
  assign prod = {ph, pl};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      done <= 1'b0;
      a_r  <= a;
      b_r  <= b;
      ph   <= '0;
      pl   <= '0;
    end else if (busy) begin
      ph   <= sum[QW:1];
      pl   <= {sum[0], pl[QW-1:1]};
      b_r  <= b_r >> 1;
      cnt  <= cnt + CNT_BITS'(1);
      busy <= (cnt != MUL_STEPS - CNT_BITS'(1));
      done <= (cnt == MUL_STEPS - CNT_BITS'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

>>> sv/arenv_div.sv
module arenv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [arenv_pkg::DVD_BITS-1:0] dividend,
  input  logic [arenv_pkg::DEN_BITS-1:0] divisor,
  input  logic [arenv_pkg::CNT_BITS-1:0] steps,
  output logic [arenv_pkg::DVD_BITS-1:0] quo,
  output logic                          done
);
  import arenv_pkg::*;

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] steps_r;
  logic [DVD_BITS-1:0] dvd;
  logic [DEN_BITS-1:0] dvs;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS:0]   rs;
  logic                fits;

  // Restoring division, one quotient bit per cycle from the top of the dividend.
  assign rs   = {rem, dvd[DVD_BITS-1]};
  assign fits = rs >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= '0;
      done    <= 1'b0;
      steps_r <= steps;
      dvd     <= dividend;
      dvs     <= divisor;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      rem  <= fits ? DEN_BITS'(rs - {1'b0, dvs}) : rs[DEN_BITS-1:0];
      quo  <= {quo[DVD_BITS-2:0], fits};
      dvd  <= dvd << 1;
      cnt  <= cnt + CNT_BITS'(1);
      busy <= (cnt != steps_r - CNT_BITS'(1));
      done <= (cnt == steps_r - CNT_BITS'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

>>> sv/attack_release_envelope_follower.sv
// Attack/release envelope follower.
// Input channel in_valid/in_ready/in_data carries one beat per audio sample:
// a signed Q1.23 sample plus attack and decay settings in Q4.12 (10 ms units).
// Output channel out_valid/out_ready/out_data carries one beat per input:
// the new envelope level (Q1.23) and a settled flag.
// cfg_we/cfg_index/cfg_data write the sample rate (index 0) and the settle
// threshold (index 1); other indexes are ignored. Write only while idle.
// One sample is worked on at a time: a new sample is taken only once the
// result of the last one has been loaded into the output register. The
// coefficient exp(-100/(rate*time)) comes from one 51-step serial divide, six
// Horner terms (each a serial multiply, five followed by a serial divide by
// the term index) and ten squarings, and the level update takes one more
// serial multiply; when the coefficient is zero, only the level update runs.
// The bit-serial multiplier and divider are shared by all these operations.
// Reset clears the envelope to zero, the rate to 48000 and the threshold to 8.
// A finished beat waits in the output register while the next sample is
// accepted; if the receiver still stalls when the next result is ready, the
// block holds that result until the output register frees up.
module attack_release_envelope_follower (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  arenv_pkg::arenv_in_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output arenv_pkg::arenv_out_t             out_data,
  input  logic                              cfg_we,
  input  logic [arenv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [arenv_pkg::CFG_BITS-1:0]    cfg_data
);
  import arenv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEN, S_CHECK, S_XDIV, S_HMUL, S_HDIV, S_SQ, S_LVL, S_OUT
  } state_t;

  state_t                 state;
  logic [RATE_BITS-1:0]   fs_rate;
  logic [THR_BITS-1:0]    settle_threshold;
  logic [SAMPLE_BITS-1:0] envelope;
  logic [SAMPLE_BITS-1:0] a_abs;
  logic                   ge;
  logic [TIME_BITS-1:0]   raw_t;
  logic                   long_t;
  logic [DEN_BITS-1:0]    den;
  logic [QW-1:0]          t_q;
  logic [2:0]             n_cnt;
  logic [3:0]             sq_cnt;
  logic [SAMPLE_BITS-1:0] lvl_r;
  logic                   settled_r;

  logic                mul_start;
  logic [QW-1:0]       mul_a;
  logic [QW-1:0]       mul_b;
  logic [PW-1:0]       mul_prod;
  logic                mul_done;
  logic                div_start;
  logic [DVD_BITS-1:0] div_dvd;
  logic [DEN_BITS-1:0] div_dvs;
  logic [CNT_BITS-1:0] div_steps;
  logic [DVD_BITS-1:0] div_quo;
  logic                div_done;

  logic [SAMPLE_BITS-1:0] s_raw;
  logic [SAMPLE_BITS-1:0] in_abs;
  logic                   in_ge;
  logic [NUM_BITS-1:0]    num;
  logic                   x_big;
  logic [QW-1:0]          p_rnd;
  logic [QW-1:0]          r_next;
  logic [QW-1:0]          coef_sum;
  logic [COEF_BITS:0]     coef_c;
  logic [COEF_BITS-1:0]   coef_sat;
  logic [SAMPLE_BITS-1:0] d_abs;
  logic [SAMPLE_BITS:0]   m_sum;
  logic [SAMPLE_BITS-1:0] m_val;

  arenv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  arenv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .quo      (div_quo),
    .done     (div_done)
  );

  assign in_ready = (state == S_IDLE);

  // Magnitude of the incoming sample and the attack/decay choice.
  assign s_raw  = in_data.sample;
  assign in_abs = s_raw[SAMPLE_BITS-1] ? (~s_raw + SAMPLE_BITS'(1)) : s_raw;
  assign in_ge  = envelope >= in_abs;

  // Exponent numerator and the check for an exponent of 32 or more.
  assign num   = long_t ? NUM_LONG : NUM_SHORT;
  assign x_big = {{(DEN_BITS-NUM_BITS+5){1'b0}}, num} >= {den, 5'b0};

  // Rounded serial product, next Horner value and the final coefficient.
  assign p_rnd    = rnd_q62(mul_prod);
  assign r_next   = Q_ONE - div_quo[QW-1:0];
  assign coef_sum = p_rnd + COEF_RND;
  assign coef_c   = coef_sum[QW-1:QW-1-COEF_BITS];
  assign coef_sat = coef_c[COEF_BITS] ? {COEF_BITS{1'b1}} : coef_c[COEF_BITS-1:0];

  // Level update terms; the distance after the update equals the step m.
  assign d_abs = ge ? (envelope - a_abs) : (a_abs - envelope);
  assign m_sum = mul_prod[2*COEF_BITS-1:COEF_BITS]
               + {{SAMPLE_BITS{1'b0}}, mul_prod[COEF_BITS-1]};
  assign m_val = m_sum[SAMPLE_BITS-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_rate          <= RATE_RESET;
      settle_threshold <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE: fs_rate          <= cfg_data[RATE_BITS-1:0];
        REG_SETTLE_THR:  settle_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer over the serial units, plus the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      envelope  <= '0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // The output register frees up on a handshake unless a new beat loads now.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          mul_start <= 1'b0;
          div_start <= 1'b0;
          if (in_valid) begin
            a_abs <= in_abs;
            ge    <= in_ge;
            raw_t <= in_ge ? in_data.decay_time : in_data.attack_time;
            state <= S_DEN;
          end
        end
        S_DEN: begin
          mul_start <= 1'b0;
          div_start <= 1'b0;
          long_t    <= raw_t >= SHORT_LIMIT;
          den       <= (raw_t < SHORT_LIMIT) ? DEN_BITS'(fs_rate)
                     : DEN_BITS'(fs_rate) * DEN_BITS'(raw_t);
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (den == '0 || x_big) begin
            // Coefficient is zero: the level jumps to the sample magnitude.
            mul_a     <= '0;
            mul_b     <= QW'(d_abs);
            mul_start <= 1'b1;
            div_start <= 1'b0;
            state     <= S_LVL;
          end else begin
            div_dvd   <= {num, {(DVD_BITS-NUM_BITS){1'b0}}};
            div_dvs   <= den;
            div_steps <= XDIV_STEPS;
            mul_start <= 1'b0;
            div_start <= 1'b1;
            state     <= S_XDIV;
          end
        end
        S_XDIV: begin
          mul_start <= div_done;
          div_start <= 1'b0;
          if (div_done) begin
            t_q   <= QW'({div_quo[XQ_BITS-1:0], {XSH{1'b0}}});
            mul_a <= QW'({div_quo[XQ_BITS-1:0], {XSH{1'b0}}});
            mul_b <= Q_ONE;
            n_cnt <= HORNER_TERMS;
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          mul_start <= mul_done && (n_cnt == 3'd1);
          div_start <= mul_done && (n_cnt != 3'd1);
          if (mul_done) begin
            if (n_cnt == 3'd1) begin
              mul_a  <= Q_ONE - p_rnd;
              mul_b  <= Q_ONE - p_rnd;
              sq_cnt <= '0;
              state  <= S_SQ;
            end else begin
              div_dvd   <= {p_rnd, 1'b0};
              div_dvs   <= DEN_BITS'(n_cnt);
              div_steps <= SDIV_STEPS;
              state     <= S_HDIV;
            end
          end
        end
        S_HDIV: begin
          mul_start <= div_done;
          div_start <= 1'b0;
          if (div_done) begin
            mul_a <= t_q;
            mul_b <= r_next;
            n_cnt <= n_cnt - 3'd1;
            state <= S_HMUL;
          end
        end
        S_SQ: begin
          mul_start <= mul_done;
          div_start <= 1'b0;
          if (mul_done) begin
            if (sq_cnt == LAST_SQUARE) begin
              mul_a <= QW'(coef_sat);
              mul_b <= QW'(d_abs);
              state <= S_LVL;
            end else begin
              mul_a  <= p_rnd;
              mul_b  <= p_rnd;
              sq_cnt <= sq_cnt + 4'd1;
            end
          end
        end
        S_LVL: begin
          mul_start <= 1'b0;
          div_start <= 1'b0;
          if (mul_done) begin
            lvl_r     <= ge ? (a_abs + m_val) : (a_abs - m_val);
            settled_r <= m_val < SAMPLE_BITS'(settle_threshold);
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          mul_start <= 1'b0;
          div_start <= 1'b0;
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_data.level   <= lvl_r;
            out_data.settled <= settled_r;
            envelope         <= lvl_r;
            state            <= S_IDLE;
          end
        end
        default: begin
          mul_start <= 1'b0;
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/arenv_chk.sv
module arenv_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input arenv_pkg::arenv_out_t             out_data
);
  import arenv_pkg::*;

  // A stalled output beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // After a sample is taken the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // No result appears the cycle after a sample is taken.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // The level never exceeds full scale.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.level <= {1'b1, {(SAMPLE_BITS-1){1'b0}}})
    else $error("level out of range");

  // Reset leaves the block idle with no pending beat.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind attack_release_envelope_follower arenv_chk u_arenv_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
